@@ rtl/chc_pkg.sv @@
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and constants of the hue classifier: controller state,
// command and status groups, color codes and datapath widths.
// ----------------------------------------------------------------------------
package chc_pkg;

    localparam int COUNT_W = 16;
    localparam int CODE_W  = 4;
    localparam int MEAN_W  = 16;
    // divisor of a hue step is 6 * (max - min), below 2^19
    localparam int DIV_W   = 19;

    localparam logic [CODE_W-1:0] COLOR_NONE   = 4'd0;
    localparam logic [CODE_W-1:0] COLOR_PURPLE = 4'd1;
    localparam logic [CODE_W-1:0] COLOR_BLUE   = 4'd2;
    localparam logic [CODE_W-1:0] COLOR_CYAN   = 4'd3;
    localparam logic [CODE_W-1:0] COLOR_GREEN  = 4'd4;
    localparam logic [CODE_W-1:0] COLOR_PINK   = 4'd5;
    localparam logic [CODE_W-1:0] COLOR_RED    = 4'd6;
    localparam logic [CODE_W-1:0] COLOR_ORANGE = 4'd7;
    localparam logic [CODE_W-1:0] COLOR_YELLOW = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_HDIV,
        ST_ACC,
        ST_MLOAD,
        ST_CLASS
    } t_state;

    typedef struct packed {
        logic load_in;
        logic load_hue;
        logic load_mean;
        logic div_step;
        logic accumulate;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic round_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/chc_ctrl.sv @@
// ----------------------------------------------------------------------------
// chc_ctrl
// Controller of the hue classifier: sequences input capture, the hue
// division, accumulation, the mean load and the round decision.
// ----------------------------------------------------------------------------
module chc_ctrl #(
    parameter int HUE_FRACTION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  chc_pkg::t_stat i_stat,
    output chc_pkg::t_cmd  o_cmd
);
    import chc_pkg::*;

    localparam int CNT_W = $clog2(HUE_FRACTION_BITS);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.load_hue = 1'b1;
                n_cnt          = CNT_W'(HUE_FRACTION_BITS - 1);
                n_state        = ST_HDIV;
            end
            ST_HDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state = i_stat.round_last ? ST_MLOAD : ST_IDLE;
            end
            ST_MLOAD: begin
                o_cmd.load_mean = 1'b1;
                n_state         = ST_CLASS;
            end
            ST_CLASS: begin
                // hold while the previous result still waits
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/chc_dpath.sv @@
// ----------------------------------------------------------------------------
// chc_dpath
// Datapath of the hue classifier: sample registers, hue operand setup, a
// radix-2 restoring hue divider, hue accumulator, mean by reciprocal
// multiply, bin compare, round decision state and the result register.
// ----------------------------------------------------------------------------
module chc_dpath #(
    parameter int SAMPLES_PER_ROUND = 16,
    parameter int HUE_FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chc_pkg::t_cmd                       i_cmd,
    output chc_pkg::t_stat                      o_stat,
    input  logic [chc_pkg::COUNT_W-1:0]         i_clear_count,
    input  logic [chc_pkg::COUNT_W-1:0]         i_red_count,
    input  logic [chc_pkg::COUNT_W-1:0]         i_green_count,
    input  logic [chc_pkg::COUNT_W-1:0]         i_blue_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [chc_pkg::CODE_W-1:0]          o_color_code,
    output logic [chc_pkg::MEAN_W-1:0]          o_mean_hue
);
    import chc_pkg::*;

    localparam int F     = HUE_FRACTION_BITS;
    localparam int IDX_W = (SAMPLES_PER_ROUND > 1) ? $clog2(SAMPLES_PER_ROUND) : 1;
    localparam int SUM_W = F + IDX_W;

    // floor(sum / SAMPLES_PER_ROUND) as (sum * RCP) >> RCP_SH, exact for SUM_W-bit sums
    localparam int RCP_SH = SUM_W + IDX_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH)
        + 64'(SAMPLES_PER_ROUND) - 64'd1) / 64'(SAMPLES_PER_ROUND));

    function automatic logic [63:0] bnd_lo(input logic [63:0] k);
        return ((k << F) + 64'd9999) / 64'd10000;
    endfunction

    function automatic logic [63:0] bnd_hi(input logic [63:0] k);
        return (k << F) / 64'd10000;
    endfunction

    localparam logic [F-1:0] OR_LO = F'(bnd_lo(64'd9920));
    localparam logic [F-1:0] OR_HI = F'(bnd_hi(64'd9990));
    localparam logic [F-1:0] RD_LO = F'(bnd_lo(64'd9750));
    localparam logic [F-1:0] RD_HI = F'(bnd_hi(64'd9919));
    localparam logic [F-1:0] PK_LO = F'(bnd_lo(64'd9200));
    localparam logic [F-1:0] PK_HI = F'(bnd_hi(64'd9749));
    localparam logic [F-1:0] PU_LO = F'(bnd_lo(64'd6201));
    localparam logic [F-1:0] PU_HI = F'(bnd_hi(64'd9190));
    localparam logic [F-1:0] BL_LO = F'(bnd_lo(64'd5210));
    localparam logic [F-1:0] BL_HI = F'(bnd_hi(64'd6200));
    localparam logic [F-1:0] CY_LO = F'(bnd_lo(64'd4700));
    localparam logic [F-1:0] CY_UP = F'(bnd_lo(64'd5200));
    localparam logic [F-1:0] GR_LO = F'(bnd_lo(64'd2100));
    localparam logic [F-1:0] GR_HI = F'(bnd_hi(64'd4690));
    localparam logic [F-1:0] YE_LO = F'(bnd_lo(64'd650));
    localparam logic [F-1:0] YE_HI = F'(bnd_hi(64'd1800));

    logic [COUNT_W-1:0] r_red, r_green, r_blue;
    logic [DIV_W-1:0]   r_rem, r_den;
    logic [F-1:0]       r_quo;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic               r_poison;
    logic [CODE_W-1:0]  r_last_color;
    logic               r_mark;
    logic               r_out_valid;
    logic [CODE_W-1:0]  r_out_code;
    logic [MEAN_W-1:0]  r_out_mean;

    // hue operands
    logic [COUNT_W-1:0] mx, mn, d;
    logic [DIV_W-1:0]   d6, num, den;

    always_comb begin
        mx = r_red;
        mn = r_red;
        if (r_green > mx) mx = r_green;
        if (r_blue  > mx) mx = r_blue;
        if (r_green < mn) mn = r_green;
        if (r_blue  < mn) mn = r_blue;
        d  = mx - mn;
        d6 = (DIV_W'(d) << 2) + (DIV_W'(d) << 1);
        priority if (r_red == mx) begin
            if (r_green >= r_blue) begin
                num = DIV_W'(r_green - r_blue);
            end else begin
                num = d6 - DIV_W'(r_blue - r_green);
            end
        end else if (r_green == mx) begin
            num = (DIV_W'(d) << 1) + DIV_W'(r_blue) - DIV_W'(r_red);
        end else begin
            num = (DIV_W'(d) << 2) + DIV_W'(r_red) - DIV_W'(r_green);
        end
        den = (d == '0) ? DIV_W'(1) : d6;
    end

    // one restoring step
    logic [DIV_W:0]   trial;
    logic             qbit;
    logic [DIV_W-1:0] rem_nx;

    always_comb begin
        trial  = {r_rem, r_quo[F-1]};
        qbit   = (trial >= {1'b0, r_den});
        rem_nx = qbit ? DIV_W'(trial - {1'b0, r_den}) : trial[DIV_W-1:0];
    end

    // round mean
    logic [PROD_W-1:0] mean_prod;
    logic [F-1:0]      mean_div;

    assign mean_prod = PROD_W'(r_sum) * PROD_W'(RCP);
    assign mean_div  = mean_prod[RCP_SH +: F];

    // bins on the mean held in the quotient register
    logic [CODE_W-1:0] bin_code, code;
    logic [F-1:0]      mean;

    always_comb begin
        priority if (r_quo >= OR_LO && r_quo <= OR_HI) bin_code = COLOR_ORANGE;
        else if (r_quo >= RD_LO && r_quo <= RD_HI)     bin_code = COLOR_RED;
        else if (r_quo >= PK_LO && r_quo <= PK_HI)     bin_code = COLOR_PINK;
        else if (r_quo >= PU_LO && r_quo <= PU_HI)     bin_code = COLOR_PURPLE;
        else if (r_quo >= BL_LO && r_quo <= BL_HI)     bin_code = COLOR_BLUE;
        else if (r_quo >= CY_LO && r_quo <  CY_UP)     bin_code = COLOR_CYAN;
        else if (r_quo >= GR_LO && r_quo <= GR_HI)     bin_code = COLOR_GREEN;
        else if (r_quo >= YE_LO && r_quo <= YE_HI)     bin_code = COLOR_YELLOW;
        else                                           bin_code = COLOR_NONE;
        code = r_poison ? COLOR_NONE : bin_code;
        mean = r_poison ? '0 : r_quo;
    end

    logic emit;
    assign emit = (code != COLOR_NONE) ? (r_last_color != code) : !r_mark;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_red   <= i_red_count;
            r_green <= i_green_count;
            r_blue  <= i_blue_count;
        end
        if (i_cmd.load_hue) begin
            r_rem <= num;
            r_den <= den;
            r_quo <= '0;
        end else if (i_cmd.load_mean) begin
            r_quo <= mean_div;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx;
            r_quo <= {r_quo[F-2:0], qbit};
        end
        if (i_cmd.finish && emit) begin
            r_out_code <= code;
            r_out_mean <= MEAN_W'(mean);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_idx        <= '0;
            r_poison     <= 1'b0;
            r_last_color <= COLOR_NONE;
            r_mark       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_in && i_clear_count == '0
                && (i_red_count | i_green_count | i_blue_count) != '0) begin
                r_poison <= 1'b1;
            end
            if (i_cmd.accumulate) begin
                r_sum <= r_sum + SUM_W'(r_quo);
                if (!o_stat.round_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_sum    <= '0;
                r_idx    <= '0;
                r_poison <= 1'b0;
                if (code != COLOR_NONE) begin
                    r_mark <= 1'b1;
                    if (emit) begin
                        r_last_color <= code;
                    end
                end else if (!r_mark) begin
                    r_last_color <= COLOR_NONE;
                end else begin
                    r_mark <= 1'b0;
                end
                if (emit) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    assign o_stat.round_last = (r_idx == IDX_W'(SAMPLES_PER_ROUND - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_color_code      = r_out_code;
    assign o_mean_hue        = r_out_mean;

endmodule

@@ rtl/color_hue_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// color_hue_classifier_unit
// Averaged-hue color classifier for clear/red/green/blue count samples.
//
//   channel   dir   handshake                  payload
//   in        in    i_in_valid / o_in_ready    i_clear/red/green/blue_count
//   out       out   o_out_valid / i_out_ready  o_color_code, o_mean_hue
//
// A sample passes operand setup, the one-bit-per-cycle hue divider and
// accumulation before the next sample is accepted. The last sample of a
// round adds the mean load and the bin decision.
// Reset clears the round accumulator, the last color and the output valid.
// The decision step holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
module color_hue_classifier_unit #(
    parameter int SAMPLES_PER_ROUND = 16,
    parameter int HUE_FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [chc_pkg::COUNT_W-1:0]  i_clear_count,
    input  logic [chc_pkg::COUNT_W-1:0]  i_red_count,
    input  logic [chc_pkg::COUNT_W-1:0]  i_green_count,
    input  logic [chc_pkg::COUNT_W-1:0]  i_blue_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [chc_pkg::CODE_W-1:0]   o_color_code,
    output logic [chc_pkg::MEAN_W-1:0]   o_mean_hue
);
    import chc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    chc_ctrl #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    chc_dpath #(
        .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_clear_count (i_clear_count),
        .i_red_count   (i_red_count),
        .i_green_count (i_green_count),
        .i_blue_count  (i_blue_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_color_code  (o_color_code),
        .o_mean_hue    (o_mean_hue)
    );

endmodule

@@ rtl/chc_checker.sv @@
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks of the hue classifier, bound to the top level.
// ----------------------------------------------------------------------------
module chc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [chc_pkg::COUNT_W-1:0]  i_clear_count,
    input logic [chc_pkg::COUNT_W-1:0]  i_red_count,
    input logic [chc_pkg::COUNT_W-1:0]  i_green_count,
    input logic [chc_pkg::COUNT_W-1:0]  i_blue_count,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [chc_pkg::CODE_W-1:0]   o_color_code,
    input logic [chc_pkg::MEAN_W-1:0]   o_mean_hue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_color_code) && $stable(o_mean_hue))
        else $error("result payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after a request was taken");

endmodule

bind color_hue_classifier_unit chc_checker u_chc_checker (.*);

@@ bench/tb_color_hue_classifier_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_hue_classifier_unit
// Self-checking bench for the averaged-hue color classifier. A table of
// directed rounds covers pure colors, hue ties, poisoned rounds, the grace
// round and gaps between bins. Random rounds of jittered, repeated, random
// and poisoned samples follow. Each result is scored by a bench-side hue
// and bin predictor or a typed row value. Both channels idle at random,
// the receiver once holds off long, and the sender once drains the block.
// ----------------------------------------------------------------------------
module tb_color_hue_classifier_unit;

    import chc_pkg::*;

    localparam int SAMPLES_PER_ROUND = 16;
    localparam int HUE_FRACTION_BITS = 16;
    localparam int DIR_ROWS          = 18;
    localparam int RANDOM_ROUNDS     = 20;
    localparam int RX_HOLD_CYCLES    = 2500;
    localparam int STALL_LIMIT       = 20000;
    localparam int TAIL_CYCLES       = 80;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_SILENT,
        ROW_EMITS
    } t_row_kind;

    typedef struct packed {
        logic [COUNT_W-1:0] clear;
        logic [COUNT_W-1:0] red;
        logic [COUNT_W-1:0] green;
        logic [COUNT_W-1:0] blue;
        logic [4:0]         reps;
        t_row_kind          kind;
        logic [CODE_W-1:0]  code;
        logic [MEAN_W-1:0]  mean;
    } t_dir_row;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [MEAN_W-1:0] mean;
    } t_hue_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [COUNT_W-1:0] i_clear_count = '0;
    logic [COUNT_W-1:0] i_red_count = '0;
    logic [COUNT_W-1:0] i_green_count = '0;
    logic [COUNT_W-1:0] i_blue_count = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [CODE_W-1:0]  o_color_code;
    logic [MEAN_W-1:0]  o_mean_hue;

    t_hue_result pending_colors[$];
    t_hue_result arrived_color;
    t_dir_row    dir_rows [DIR_ROWS];

    logic [19:0]       hue_acc = '0;
    int                samples_seen = 0;
    bit                round_poisoned = 1'b0;
    logic [CODE_W-1:0] last_code = COLOR_NONE;
    bit                color_mark = 1'b0;

    int mismatch_count = 0;
    int idle_cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_hold_req = 1'b0;

    color_hue_classifier_unit #(
        .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_clear_count (i_clear_count),
        .i_red_count   (i_red_count),
        .i_green_count (i_green_count),
        .i_blue_count  (i_blue_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_color_code  (o_color_code),
        .o_mean_hue    (o_mean_hue)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [MEAN_W-1:0] sample_hue(input logic [COUNT_W-1:0] r, g, b);
        logic [COUNT_W-1:0] mx;
        logic [COUNT_W-1:0] mn;
        logic [39:0]        spread;
        logic [39:0]        num;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (mx == mn) return '0;
        spread = 40'(mx - mn);
        if (r == mx)
            num = (g >= b) ? 40'(g - b) : spread * 6 - 40'(b - g);
        else if (g == mx)
            num = spread * 2 + 40'(b) - 40'(r);
        else
            num = spread * 4 + 40'(r) - 40'(g);
        return MEAN_W'((num << HUE_FRACTION_BITS) / (spread * 6));
    endfunction

    function automatic longint unsigned lower_bound(input longint unsigned k);
        return ((k << HUE_FRACTION_BITS) + 9999) / 10000;
    endfunction

    function automatic longint unsigned upper_bound(input longint unsigned k);
        return (k << HUE_FRACTION_BITS) / 10000;
    endfunction

    function automatic bit in_span(input logic [MEAN_W-1:0] m, input longint unsigned lo, hi);
        return (m >= lower_bound(lo)) && (m <= upper_bound(hi));
    endfunction

    function automatic logic [CODE_W-1:0] hue_bin(input logic [MEAN_W-1:0] m);
        if (in_span(m, 9920, 9990)) return COLOR_ORANGE;
        if (in_span(m, 9750, 9919)) return COLOR_RED;
        if (in_span(m, 9200, 9749)) return COLOR_PINK;
        if (in_span(m, 6201, 9190)) return COLOR_PURPLE;
        if (in_span(m, 5210, 6200)) return COLOR_BLUE;
        if (m >= lower_bound(4700) && m < lower_bound(5200)) return COLOR_CYAN;
        if (in_span(m, 2100, 4690)) return COLOR_GREEN;
        if (in_span(m, 650, 1800)) return COLOR_YELLOW;
        return COLOR_NONE;
    endfunction

    task automatic hue_classify_step(input logic [COUNT_W-1:0] c, r, g, b,
                                     output bit emits, output t_hue_result res);
        logic [CODE_W-1:0] code;
        logic [MEAN_W-1:0] mean;
        emits = 1'b0;
        res = '0;
        if (c == '0 && (r | g | b) != '0) round_poisoned = 1'b1;
        hue_acc = hue_acc + 20'(sample_hue(r, g, b));
        samples_seen++;
        if (samples_seen == SAMPLES_PER_ROUND) begin
            mean = round_poisoned ? '0 : MEAN_W'(hue_acc / SAMPLES_PER_ROUND);
            code = round_poisoned ? COLOR_NONE : hue_bin(mean);
            if (code != COLOR_NONE) begin
                color_mark = 1'b1;
                if (code != last_code) begin
                    last_code = code;
                    emits = 1'b1;
                end
            end else if (!color_mark) begin
                last_code = COLOR_NONE;
                emits = 1'b1;
            end else begin
                color_mark = 1'b0;
            end
            res.code = code;
            res.mean = mean;
            hue_acc = '0;
            samples_seen = 0;
            round_poisoned = 1'b0;
        end
    endtask

    function automatic t_dir_row dir_row(input logic [COUNT_W-1:0] c, r, g, b,
                                         input int reps, input t_row_kind kind,
                                         input logic [CODE_W-1:0] code,
                                         input logic [MEAN_W-1:0] mean);
        t_dir_row row;
        row.clear = c;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        row.reps  = 5'(reps);
        row.kind  = kind;
        row.code  = code;
        row.mean  = mean;
        return row;
    endfunction

    // Call at a rising edge; returns at the edge that accepts the request.
    task automatic send_sample(input logic [COUNT_W-1:0] c, r, g, b,
                               input t_row_kind kind, input t_hue_result typed);
        int          gap;
        bit          emits;
        t_hue_result res;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_clear_count <= c;
        i_red_count   <= r;
        i_green_count <= g;
        i_blue_count  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        hue_classify_step(c, r, g, b, emits, res);
        if (kind == ROW_EMITS) begin
            pending_colors.push_back(typed);
        end else if (kind == ROW_MODEL && emits) begin
            pending_colors.push_back(res);
        end
    endtask

    initial begin : stimulus
        int                 rep;
        int                 round;
        int                 mode;
        int                 poison_at;
        logic [COUNT_W-1:0] br, bg, bb;
        logic [COUNT_W-1:0] sc, sr, sg, sb;
        t_hue_result        typed;
        t_row_kind          kind;

        dir_rows[0]  = dir_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16, ROW_EMITS,
                               COLOR_NONE, 16'd0);
        dir_rows[1]  = dir_row(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16, ROW_EMITS,
                               COLOR_GREEN, 16'd21845);
        dir_rows[2]  = dir_row(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16, ROW_EMITS,
                               COLOR_PURPLE, 16'd43690);
        dir_rows[3]  = dir_row(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16, ROW_SILENT,
                               COLOR_NONE, 16'd0);
        dir_rows[4]  = dir_row(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16, ROW_SILENT,
                               COLOR_NONE, 16'd0);
        dir_rows[5]  = dir_row(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16, ROW_EMITS,
                               COLOR_NONE, 16'd0);
        dir_rows[6]  = dir_row(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[7]  = dir_row(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 15, ROW_EMITS,
                               COLOR_NONE, 16'd0);
        dir_rows[8]  = dir_row(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16, ROW_EMITS,
                               COLOR_PURPLE, 16'd54613);
        dir_rows[9]  = dir_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16, ROW_EMITS,
                               COLOR_YELLOW, 16'd10922);
        dir_rows[10] = dir_row(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16, ROW_EMITS,
                               COLOR_CYAN, 16'd32768);
        dir_rows[11] = dir_row(16'd5000, 16'd1000, 16'd0, 16'd30, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[12] = dir_row(16'd5000, 16'd1000, 16'd0, 16'd100, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[13] = dir_row(16'd5000, 16'd1000, 16'd0, 16'd300, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[14] = dir_row(16'd5000, 16'd0, 16'd580, 16'd1000, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[15] = dir_row(16'd5000, 16'd800, 16'd1000, 16'd0, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[16] = dir_row(16'd5000, 16'd800, 16'd1000, 16'd0, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);
        dir_rows[17] = dir_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16, ROW_MODEL,
                               COLOR_NONE, 16'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            tx_burst = ($urandom_range(0, 2) == 0);
            for (rep = 0; rep < dir_rows[i].reps; rep++) begin
                typed.code = dir_rows[i].code;
                typed.mean = dir_rows[i].mean;
                kind = (rep == dir_rows[i].reps - 1) ? dir_rows[i].kind : ROW_MODEL;
                send_sample(dir_rows[i].clear, dir_rows[i].red, dir_rows[i].green,
                            dir_rows[i].blue, kind, typed);
            end
        end

        br = '0;
        bg = '0;
        bb = '0;
        typed = '0;
        round = 0;
        while (round < RANDOM_ROUNDS) begin
            if (round == 10) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_colors.size() != 0);
            end
            if (round == 3) rx_hold_req = 1'b1;
            tx_burst = (round >= 3 && round <= 7) || ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (mode >= 2 || (round >= 3 && round <= 7)) begin
                br = COUNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
                bg = COUNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
                bb = COUNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            end
            poison_at = $urandom_range(0, SAMPLES_PER_ROUND - 1);
            for (rep = 0; rep < SAMPLES_PER_ROUND; rep++) begin
                sc = COUNT_W'($urandom_range(1, 65535));
                sr = br ^ COUNT_W'($urandom_range(0, 3));
                sg = bg ^ COUNT_W'($urandom_range(0, 3));
                sb = bb ^ COUNT_W'($urandom_range(0, 3));
                if (mode == 6 || mode == 7) begin
                    sc = COUNT_W'($urandom);
                    sr = COUNT_W'($urandom);
                    sg = COUNT_W'($urandom);
                    sb = COUNT_W'($urandom);
                end else if (mode == 8 && rep == poison_at) begin
                    sc = '0;
                    sr = sr | COUNT_W'(1);
                end else if (mode == 9 && $urandom_range(0, 2) == 0) begin
                    sc = COUNT_W'($urandom);
                    sr = '0;
                    sg = '0;
                    sb = '0;
                end
                send_sample(sc, sr, sg, sb, ROW_MODEL, typed);
            end
            round++;
        end

        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS color_hue_classifier_unit");
        else
            $display("FAIL color_hue_classifier_unit");
        $finish;
    end

    initial begin : receiver
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result code %0d mean %0d",
                         $time, o_color_code, o_mean_hue);
                mismatch_count++;
            end else begin
                arrived_color = pending_colors.pop_front();
                if (arrived_color.code != o_color_code) begin
                    $display("%0t: color_code expected %0d, got %0d",
                             $time, arrived_color.code, o_color_code);
                    mismatch_count++;
                end
                if (arrived_color.mean != o_mean_hue) begin
                    $display("%0t: mean_hue expected %0d, got %0d",
                             $time, arrived_color.mean, o_mean_hue);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL color_hue_classifier_unit");
            $finish;
        end
    end

endmodule
